FILE: rtl/hcl_pkg.sv
// ----------------------------------------------------------------------------
// hcl_pkg
// Types, widths and byte classification shared by the host name checker.
// ----------------------------------------------------------------------------
package hcl_pkg;

    localparam int unsigned TotalWidth = 9;
    localparam int unsigned LabelWidth = 7;

    localparam logic [7:0] ChrHyphen     = 8'h2d;
    localparam logic [7:0] ChrDot        = 8'h2e;
    localparam logic [7:0] ChrUnderscore = 8'h5f;
    localparam logic [7:0] ChrDigit0     = 8'h30;
    localparam logic [7:0] ChrDigit9     = 8'h39;
    localparam logic [7:0] ChrUpperA     = 8'h41;
    localparam logic [7:0] ChrUpperZ     = 8'h5a;
    localparam logic [7:0] ChrLowerA     = 8'h61;
    localparam logic [7:0] ChrLowerZ     = 8'h7a;
    localparam logic [7:0] CaseOffset    = 8'h20;

    typedef logic [TotalWidth-1:0] t_total;
    typedef logic [LabelWidth-1:0] t_label;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       final_byte;
    } t_beat;

    typedef struct packed {
        logic [7:0] lower_byte;
        logic       name_done;
        logic       name_valid;
    } t_result;

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= ChrUpperA) && (b <= ChrUpperZ);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return is_upper(b) ? 8'(b + CaseOffset) : b;
    endfunction

    function automatic logic is_label_byte(input logic [7:0] b);
        return (b == ChrHyphen) || (b == ChrUnderscore)
            || ((b >= ChrDigit0) && (b <= ChrDigit9))
            || is_upper(b)
            || ((b >= ChrLowerA) && (b <= ChrLowerZ));
    endfunction

endpackage

FILE: rtl/hcl_in_stage.sv
// ----------------------------------------------------------------------------
// hcl_in_stage
// Input register: captures one byte beat and holds it until the check
// stage consumes it.
// ----------------------------------------------------------------------------
module hcl_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  hcl_pkg::t_beat i_beat,
    input  logic           i_take,
    output logic           o_stall,
    output logic           o_full,
    output hcl_pkg::t_beat o_beat
);

    logic           r_full;
    logic           n_full;
    hcl_pkg::t_beat r_beat;
    logic           load;

    // Stall only while a held beat cannot move on this cycle.
    assign o_stall = r_full && !i_take;
    assign load    = i_valid && !o_stall;
    assign n_full  = load || (r_full && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= i_beat;
        end
    end

    assign o_full = r_full;
    assign o_beat = r_beat;

endmodule

FILE: rtl/hcl_check.sv
// ----------------------------------------------------------------------------
// hcl_check
// Name state (lengths, hyphen flag, sticky error) and the per-byte rule
// check; produces the lower-cased byte and the verdict for one beat.
// ----------------------------------------------------------------------------
module hcl_check #(
    parameter int unsigned MAX_NAME_LEN  = 255,
    parameter int unsigned MAX_LABEL_LEN = 63
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hcl_pkg::t_beat   i_beat,
    input  logic             i_take,
    output hcl_pkg::t_result o_result
);

    localparam hcl_pkg::t_total TotalLimit = hcl_pkg::t_total'(MAX_NAME_LEN);
    localparam hcl_pkg::t_label LabelLimit = hcl_pkg::t_label'(MAX_LABEL_LEN);
    localparam hcl_pkg::t_total TotalSat   = '1;
    localparam hcl_pkg::t_label LabelSat   = '1;

    hcl_pkg::t_total r_total, n_total;
    hcl_pkg::t_label r_label, n_label;
    logic            r_hyphen, n_hyphen;
    logic            r_error, n_error;

    logic [7:0] b;
    logic       is_dot;
    logic       is_hyphen;
    logic       label_empty;
    logic       byte_error;

    assign b           = i_beat.name_byte;
    assign is_dot      = (b == hcl_pkg::ChrDot);
    assign is_hyphen   = (b == hcl_pkg::ChrHyphen);
    assign label_empty = (r_label == '0);

    always_comb begin
        if (is_dot) begin
            // Close the label: must be non-empty and not end in a hyphen.
            byte_error = label_empty || r_hyphen;
            n_label    = '0;
            n_hyphen   = 1'b0;
        end else begin
            byte_error = !hcl_pkg::is_label_byte(b) || (is_hyphen && label_empty)
                      || (r_label >= LabelLimit);
            n_label    = (r_label < LabelSat) ? r_label + 1'b1 : r_label;
            n_hyphen   = is_hyphen;
        end
        n_error = r_error || byte_error || (r_total >= TotalLimit);
        n_total = (r_total < TotalSat) ? r_total + 1'b1 : r_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_label  <= '0;
            r_hyphen <= 1'b0;
            r_error  <= 1'b0;
        end else if (i_take) begin
            if (i_beat.final_byte) begin
                r_total  <= '0;
                r_label  <= '0;
                r_hyphen <= 1'b0;
                r_error  <= 1'b0;
            end else begin
                r_total  <= n_total;
                r_label  <= n_label;
                r_hyphen <= n_hyphen;
                r_error  <= n_error;
            end
        end
    end

    assign o_result.lower_byte = hcl_pkg::to_lower(b);
    assign o_result.name_done  = i_beat.final_byte;
    assign o_result.name_valid = i_beat.final_byte && !n_error && !n_hyphen;

endmodule

FILE: rtl/hcl_out_stage.sv
// ----------------------------------------------------------------------------
// hcl_out_stage
// Result register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module hcl_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load_valid,
    input  hcl_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_take,
    output logic             o_valid,
    output hcl_pkg::t_result o_result
);

    logic             r_valid;
    hcl_pkg::t_result r_result;
    logic             open;

    // Register is free when empty or when its beat leaves this cycle.
    assign open   = !r_valid || !i_stall;
    assign o_take = i_load_valid && open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (open) begin
            r_valid <= i_load_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: rtl/hostname_check_lowercase.sv
// ----------------------------------------------------------------------------
// hostname_check_lowercase
// Streaming host name checker: lower-cases each byte and gives a verdict
// on the final byte of every name.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with i_name_byte and i_final_byte; a beat
// is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_lower_byte, o_name_done and
// o_name_valid; exactly one result beat per input beat, in order.
// o_name_valid is only meaningful when o_name_done is set, and is 0
// otherwise.
// A beat passes through the input register, then the check logic feeding
// the result register. Throughput is one byte per cycle while i_stall is
// low, as the check stage updates its length/label state on each beat.
// When i_stall holds the result register, the input register still takes
// one beat; o_stall rises only when both registers are full.
// Reset (i_rst_n low, synchronous) empties both registers and clears the
// length counters, hyphen flag and error flag. They also clear after each
// final byte, ready for the next name.
// ----------------------------------------------------------------------------
module hostname_check_lowercase #(
    parameter int unsigned MAX_NAME_LEN  = 255,
    parameter int unsigned MAX_LABEL_LEN = 63
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_name_byte,
    input  logic       i_final_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_lower_byte,
    output logic       o_name_done,
    output logic       o_name_valid
);

    hcl_pkg::t_beat   in_beat;
    hcl_pkg::t_beat   held_beat;
    hcl_pkg::t_result check_result;
    hcl_pkg::t_result out_result;
    logic             held_full;
    logic             take;

    assign in_beat.name_byte  = i_name_byte;
    assign in_beat.final_byte = i_final_byte;

    hcl_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_beat  (in_beat),
        .i_take  (take),
        .o_stall (o_stall),
        .o_full  (held_full),
        .o_beat  (held_beat)
    );

    hcl_check #(
        .MAX_NAME_LEN  (MAX_NAME_LEN),
        .MAX_LABEL_LEN (MAX_LABEL_LEN)
    ) u_check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_beat   (held_beat),
        .i_take   (take),
        .o_result (check_result)
    );

    hcl_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (held_full),
        .i_result     (check_result),
        .i_stall      (i_stall),
        .o_take       (take),
        .o_valid      (o_valid),
        .o_result     (out_result)
    );

    assign o_lower_byte = out_result.lower_byte;
    assign o_name_done  = out_result.name_done;
    assign o_name_valid = out_result.name_valid;

`ifndef SYNTHESIS
    a_verdict_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_name_valid |-> o_name_done)
        else $error("verdict valid without end of name");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipeline not empty after reset");

    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> held_full && o_valid && i_stall)
        else $error("input stalled while a stage is free");

    a_take_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_valid)
        else $error("checked beat lost before result register");
`endif

endmodule
